FILE: rtl/bss_pkg.sv
package bss_pkg;

  // Command codes carried in the op field.
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_DUMP   = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_SORT   = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADOP    = 3'd4;

  // One input item.
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] operand;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data;
    logic [5:0]         position;
    logic               last;
  } out_t;

  // Memory read address source.
  typedef enum logic [1:0] {
    ASEL_TOP,
    ASEL_I,
    ASEL_J
  } addr_sel_e;

  // Memory write address and data source.
  typedef enum logic [1:0] {
    WSEL_PUSH,
    WSEL_SWAP,
    WSEL_FINAL
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       rd_en;
    addr_sel_e  rd_sel;
    logic       wr_en;
    wr_sel_e    wr_sel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       i_clr;
    logic       i_inc;
    logic       j_from_i;
    logic       j_inc;
    logic       cur_load;
    logic       emit;
    logic [2:0] emit_status;
    logic       emit_rdata;
    logic       emit_pos;
    logic       emit_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       i_last;
    logic       i_end;
    logic       j_end;
    logic       gt;
    logic       eq;
    logic       out_free;
  } stat_t;

endpackage

FILE: rtl/bounded_stack_search_sort.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i, in_stall_o | in_data_i  (op, operand)
// out     | output    | out_valid_o, out_stall_i | out_data_o (status, data, position, last)
//
// Dump reads and emits the entries one by one; search reads entries until one matches,
// and a search that misses reports not found after the last entry.
// Sort speed is set by the single read port of the stack memory serving each
// compare-exchange step.
// Reset clears the entry count and the controller; stored values need none.
// A stalled output holds the result and pauses the controller in place.
module bounded_stack_search_sort
  import bss_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer for each command.
  bss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Stack memory, counters and output register.
  bss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/bss_dp.sv
module bss_dp
  import bss_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   in_data_i,
  input  logic  out_stall_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output logic  out_valid_o,
  output out_t  out_data_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [31:0] mem [DEPTH];

  logic [2:0]         op_q;
  logic signed [31:0] operand_q;
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      i_q;
  logic [CW-1:0]      j_q;
  logic signed [31:0] cur_q;
  logic signed [31:0] rdata_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      rd_ptr;
  logic [CW-1:0]      wr_ptr;
  logic signed [31:0] wr_data;
  logic [CW:0]        i_p1;

  assign cnt_m1 = cnt_q - CW'(1);
  assign i_p1   = {1'b0, i_q} + (CW + 1)'(1);

  // Read address selection.
  always_comb begin
    case (cmd_i.rd_sel)
      ASEL_TOP: rd_ptr = cnt_m1;
      ASEL_I:   rd_ptr = i_q;
      ASEL_J:   rd_ptr = j_q;
      default:  rd_ptr = i_q;
    endcase
  end

  // Write address and data selection.
  always_comb begin
    case (cmd_i.wr_sel)
      WSEL_PUSH: begin
        wr_ptr  = cnt_q;
        wr_data = operand_q;
      end
      WSEL_SWAP: begin
        wr_ptr  = j_q;
        wr_data = cur_q;
      end
      WSEL_FINAL: begin
        wr_ptr  = i_q;
        wr_data = cur_q;
      end
      default: begin
        wr_ptr  = i_q;
        wr_data = cur_q;
      end
    endcase
  end

  // Stack storage with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_ptr[AW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_ptr[AW-1:0]];
    end
  end

  // Captured command, running value and loop indexes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= in_data_i.op;
      operand_q <= in_data_i.operand;
    end
    if (cmd_i.cur_load) begin
      cur_q <= rdata_q;
    end
    if (cmd_i.i_clr) begin
      i_q <= '0;
    end else if (cmd_i.i_inc) begin
      i_q <= i_q + CW'(1);
    end
    if (cmd_i.j_from_i) begin
      j_q <= i_p1[CW-1:0];
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + CW'(1);
    end
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_m1;
    end
  end

  // Output register: a result waits here until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status   <= cmd_i.emit_status;
      out_q.data     <= cmd_i.emit_rdata ? rdata_q : 32'sd0;
      out_q.position <= cmd_i.emit_pos ? 6'(i_q) : 6'd0;
      out_q.last     <= cmd_i.emit_last;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o.op       = op_q;
    stat_o.full     = (cnt_q == CW'(DEPTH));
    stat_o.empty    = (cnt_q == '0);
    stat_o.i_last   = (i_p1 >= {1'b0, cnt_q});
    stat_o.i_end    = (i_q == cnt_q);
    stat_o.j_end    = (j_q >= cnt_q);
    stat_o.gt       = (cur_q > rdata_q);
    stat_o.eq       = (rdata_q == operand_q);
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/bss_ctrl.sv
module bss_ctrl
  import bss_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output logic  in_stall_o,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EMIT,
    S_DUMP_RD,
    S_DUMP_EM,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SORT_I,
    S_SORT_IW,
    S_SORT_J,
    S_SORT_CMP
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] code_q, code_d;
  logic       rdat_q, rdat_d;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    rdat_d  = rdat_q;
    cmd_o   = '0;
    cmd_o.rd_sel = ASEL_I;
    cmd_o.wr_sel = WSEL_FINAL;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        rdat_d      = 1'b0;
        code_d      = ST_OK;
        cmd_o.i_clr = 1'b1;
        state_d     = S_EMIT;
        if (stat_i.op == OP_PUSH) begin
          if (stat_i.full) begin
            code_d = ST_FULL;
          end else begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_sel  = WSEL_PUSH;
            cmd_o.cnt_inc = 1'b1;
          end
        end else if (stat_i.op > OP_SORT) begin
          code_d = ST_BADOP;
        end else if (stat_i.empty) begin
          code_d = ST_EMPTY;
        end else begin
          case (stat_i.op)
            OP_POP: begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_sel  = ASEL_TOP;
              cmd_o.cnt_dec = 1'b1;
              rdat_d        = 1'b1;
            end
            OP_DUMP:   state_d = S_DUMP_RD;
            OP_SEARCH: state_d = S_SRCH_RD;
            OP_SORT:   state_d = S_SORT_I;
            default:   code_d = ST_BADOP;
          endcase
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = code_q;
          cmd_o.emit_rdata  = rdat_q;
          cmd_o.emit_last   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_DUMP_EM;
      end
      S_DUMP_EM: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_rdata  = 1'b1;
          cmd_o.emit_pos    = 1'b1;
          cmd_o.emit_last   = stat_i.i_last;
          if (stat_i.i_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.i_inc = 1'b1;
            state_d = S_DUMP_RD;
          end
        end
      end
      S_SRCH_RD: begin
        if (stat_i.i_end) begin
          code_d  = ST_NOTFOUND;
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (stat_i.eq) begin
          if (stat_i.out_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_OK;
            cmd_o.emit_rdata  = 1'b1;
            cmd_o.emit_pos    = 1'b1;
            cmd_o.emit_last   = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d = S_SRCH_RD;
        end
      end
      S_SORT_I: begin
        // The last entry needs no pass of its own.
        if (stat_i.i_last) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.j_from_i = 1'b1;
          state_d = S_SORT_IW;
        end
      end
      S_SORT_IW: begin
        cmd_o.cur_load = 1'b1;
        state_d = S_SORT_J;
      end
      S_SORT_J: begin
        if (stat_i.j_end) begin
          // The smallest value seen in this pass settles at slot i.
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WSEL_FINAL;
          cmd_o.i_inc  = 1'b1;
          state_d = S_SORT_I;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ASEL_J;
          state_d = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        if (stat_i.gt) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_sel   = WSEL_SWAP;
          cmd_o.cur_load = 1'b1;
        end
        cmd_o.j_inc = 1'b1;
        state_d = S_SORT_J;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered result selection.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
      rdat_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      rdat_q  <= rdat_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
